[hdl/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants
// Status codes, frame limits and the item/result records that pass
// between the response checker modules.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;
    localparam int CRC_W   = 16;
    localparam int VALUE_W = 16;
    localparam int HDR_N   = 5;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [BYTE_W-1:0] EXC_BIT   = 8'h80;
    localparam logic [CNT_W-1:0]  MIN_LEN   = 4'd5;
    localparam logic [CNT_W-1:0]  REG_LEN   = 4'd7;
    localparam logic [BYTE_W-1:0] REG_BYTES = 8'd2;
    localparam logic [CNT_W-1:0]  BUF_REG   = 4'd8;
    localparam logic [CNT_W-1:0]  BUF_BIT   = 4'd7;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 4'd15;

    localparam logic [BYTE_W-1:0] SLAVE_RESET = 8'd1;
    localparam logic [ADDR_W-1:0] ADDR_SLAVE  = 2'd0;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RXERR = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_SLAVE = 3'd4;
    localparam logic [2:0] ST_EXC   = 3'd5;
    localparam logic [2:0] ST_FUNC  = 3'd6;
    localparam logic [2:0] ST_DATA  = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              last;
        logic [1:0]        cmd;
    } mrc_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  exc_code;
    } mrc_result_t;

endpackage

[hdl/mrc_crc16.sv]
// ----------------------------------------------------------------------------
// mrc_crc16: one-byte CRC-16 update
// Reflected Modbus CRC, eight shift steps unrolled into combinational logic.
// ----------------------------------------------------------------------------
module mrc_crc16
    import mrc_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data_in,
    output logic [CRC_W-1:0]  crc_out
);

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

[hdl/mrc_frame.sv]
// ----------------------------------------------------------------------------
// mrc_frame: frame state and response checks
// Holds CRC, byte count, header and tail bytes; on the last byte of a
// frame forms the status, decoded value and exception code, then clears the frame.
// ----------------------------------------------------------------------------
module mrc_frame
    import mrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  mrc_item_t         item,
    input  logic [BYTE_W-1:0] slave_address,
    output mrc_result_t       result
);

    logic [CRC_W-1:0]  crc_reg,   crc_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [BYTE_W-1:0] hdr_reg  [HDR_N];
    logic [BYTE_W-1:0] hdr_next [HDR_N];
    logic [BYTE_W-1:0] tail0_reg, tail0_next;
    logic [BYTE_W-1:0] tail1_reg, tail1_next;
    logic [CRC_W-1:0]  crc_upd;
    logic              reg_read;
    logic [CNT_W-1:0]  buf_len;
    logic [BYTE_W-1:0] bc;

    mrc_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (tail0_reg),
        .crc_out (crc_upd)
    );

    // state after taking this byte
    always_comb
    begin
        crc_next   = (cnt_reg >= 4'd2) ? crc_upd : crc_reg;
        tail0_next = tail1_reg;
        tail1_next = item.rx_byte;
        for (int k = 0; k < HDR_N; k++)
        begin
            hdr_next[k] = (cnt_reg == CNT_W'(k)) ? item.rx_byte : hdr_reg[k];
        end
        cnt_next = (cnt_reg < COUNT_MAX) ? cnt_reg + 4'd1 : cnt_reg;
    end

    assign reg_read = item.cmd[1];
    assign buf_len  = reg_read ? BUF_REG : BUF_BIT;
    assign bc       = hdr_next[2];

    always_comb
    begin
        result = '0;
        priority if (cnt_next == '0 || cnt_next > buf_len)
            result.status = ST_RXERR;
        else if (cnt_next < MIN_LEN)
            result.status = ST_SHORT;
        else if (crc_next != {tail1_next, tail0_next})
            result.status = ST_CRC;
        else if (hdr_next[0] != slave_address)
            result.status = ST_SLAVE;
        else if ((hdr_next[1] & EXC_BIT) != '0)
        begin
            result.status   = ST_EXC;
            result.exc_code = hdr_next[2];
        end
        else if (hdr_next[1] != {6'd0, item.cmd} + 8'd1)
            result.status = ST_FUNC;
        else if (reg_read)
        begin
            if (cnt_next != REG_LEN || bc != REG_BYTES)
                result.status = ST_DATA;
            else
                result.value = {hdr_next[3], hdr_next[4]};
        end
        else
        begin
            // bit read: byte count 1 or 2, frame length byte count plus five
            if (!((bc == 8'd1 && cnt_next == MIN_LEN + 4'd1) ||
                  (bc == 8'd2 && cnt_next == MIN_LEN + 4'd2)))
                result.status = ST_DATA;
            else if (bc == 8'd2)
                result.value = {hdr_next[4], hdr_next[3]};
            else
                result.value = {8'h00, hdr_next[3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            cnt_reg   <= '0;
            tail0_reg <= '0;
            tail1_reg <= '0;
            for (int k = 0; k < HDR_N; k++)
                hdr_reg[k] <= '0;
        end
        else if (go)
        begin
            if (item.last)
            begin
                crc_reg   <= CRC_INIT;
                cnt_reg   <= '0;
                tail0_reg <= '0;
                tail1_reg <= '0;
                for (int k = 0; k < HDR_N; k++)
                    hdr_reg[k] <= '0;
            end
            else
            begin
                crc_reg   <= crc_next;
                cnt_reg   <= cnt_next;
                tail0_reg <= tail0_next;
                tail1_reg <= tail1_next;
                for (int k = 0; k < HDR_N; k++)
                    hdr_reg[k] <= hdr_next[k];
            end
        end
    end

endmodule

[hdl/modbus_rtu_response_checker_unit.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit: Modbus RTU response frame checker
// Checks CRC, address, function and length of a read response and
// decodes the returned register or bitfield.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one response byte per item in line
//   order, with last marking the final byte and cmd the requested read.
//   Output channel (out_valid / out_stall): one result item per frame,
//   given for the last byte only: status, value, exc_code.
//   APB port: one register, slave_address at byte address 0 (reset 1).
//   Path: a last byte accepted into the input register passes the check
//   logic into the result register; it waits in the input register
//   only while a previous result is still stalled.
//   Throughput: one byte per cycle; the CRC byte update and the checks sit
//   in a single stage between the input register and the result register.
//   A stalled receiver holds the result; bytes that are not last keep
//   flowing into the frame state, and a last byte waits in the input
//   register until the result slot frees, which then stalls the sender.
//   Reset: frame state cleared (CRC FFFF, count zero), slave_address back
//   to 1, both channels empty.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit
    import mrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic               last,
    input  logic [1:0]         cmd,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [VALUE_W-1:0] value,
    output logic [BYTE_W-1:0]  exc_code,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic              s1_vld_reg, s1_vld_next;
    mrc_item_t         s1_item_reg;
    logic              s1_go;
    logic              in_take;
    logic              out_free;
    logic              out_load;
    logic              out_vld_reg, out_vld_next;
    mrc_result_t       out_res_reg;
    mrc_result_t       res;
    logic [BYTE_W-1:0] slave_reg;

    // ---- configuration register ----
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SLAVE) ? {24'd0, slave_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_reg <= SLAVE_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_SLAVE)
            slave_reg <= pwdata[BYTE_W-1:0];
    end

    // ---- handshake ----
    // a byte that is not last never needs the result slot
    assign out_free     = !out_vld_reg || !out_stall;
    assign s1_go        = s1_vld_reg && (!s1_item_reg.last || out_free);
    assign in_stall     = s1_vld_reg && !s1_go;
    assign in_take      = in_valid && !in_stall;
    assign out_load     = s1_go && s1_item_reg.last;
    assign s1_vld_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_vld_reg);
    assign out_vld_next = out_load ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);

    // ---- input register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.rx_byte <= rx_byte;
            s1_item_reg.last    <= last;
            s1_item_reg.cmd     <= cmd;
        end
    end

    // ---- frame state and checks ----
    mrc_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (s1_go),
        .item          (s1_item_reg),
        .slave_address (slave_reg),
        .result        (res)
    );

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign status    = out_res_reg.status;
    assign value     = out_res_reg.value;
    assign exc_code  = out_res_reg.exc_code;

`ifndef SYNTHESIS
    // a last byte that leaves the input register always shows a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("last byte did not produce a result");

    // the input side only stalls while an item is parked in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_vld_reg && s1_item_reg.last && out_vld_reg)
        else $error("input stalled without a blocked last byte");

    // value is zero unless the frame checked out
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value == '0)
        else $error("nonzero value on failed frame");

    // exception code only accompanies an exception status
    a_exc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_EXC |-> exc_code == '0)
        else $error("exception code outside exception status");
`endif

endmodule

[tb/sv/modbus_rtu_response_checker_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit_test: self-checking bench for the checker
// Feeds Modbus RTU response frames byte by byte (good, exception, corrupted,
// short, long and pure noise), predicts status/value/exc_code per
// frame and checks every result against the oldest prediction. Both channels
// idle and stall at random; slave_address is changed over the APB port
// between phases.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit_test;
    import mrc_pkg::*;

    // requested read kinds; function code on the wire is cmd + 1
    localparam logic [1:0] CMD_COILS    = 2'd0;
    localparam logic [1:0] CMD_DISCRETE = 2'd1;
    localparam logic [1:0] CMD_HOLDING  = 2'd2;
    localparam logic [1:0] CMD_INPUT    = 2'd3;

    localparam int RANDOM_ITEMS = 430;
    localparam int DRAIN_CYCLES = 6;     // flush wait; the result register loads after the last byte
    localparam int CYCLE_LIMIT  = 500000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte = '0;
    logic               last = 1'b0;
    logic [1:0]         cmd = CMD_COILS;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [VALUE_W-1:0] value;
    logic [BYTE_W-1:0]  exc_code;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    modbus_rtu_response_checker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .last      (last),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value     (value),
        .exc_code  (exc_code),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Frame model: own copy of the checker state, updated per accepted item
    // ------------------------------------------------------------------
    logic [CRC_W-1:0]  fm_crc = CRC_INIT;
    logic [CNT_W-1:0]  fm_count = '0;
    logic [BYTE_W-1:0] fm_hdr [HDR_N];
    logic [BYTE_W-1:0] fm_tail [2];
    logic [BYTE_W-1:0] fm_slave = SLAVE_RESET;

    mrc_result_t awaited_results [$];   // predicted frame results, oldest first
    logic [BYTE_W-1:0] frame_buf [$];   // bytes of the frame being built

    int  errors = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_stall_on = 1'b0;
    int  stall_left = 0;
    int  open_left = 0;

    initial
    begin
        for (int i = 0; i < HDR_N; i++)
            fm_hdr[i] = '0;
        fm_tail[0] = '0;
        fm_tail[1] = '0;
    end

    // Modbus CRC-16, LSB first, one byte
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void clear_frame_model();
        fm_crc   = CRC_INIT;
        fm_count = '0;
        for (int i = 0; i < HDR_N; i++)
            fm_hdr[i] = '0;
        fm_tail[0] = '0;
        fm_tail[1] = '0;
    endfunction

    // Advances the model by one byte; returns 1 with the frame result on a last byte.
    function automatic bit predict_frame_result(input logic [BYTE_W-1:0] b,
                                                input logic l, input logic [1:0] c,
                                                output mrc_result_t r);
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  rx_limit;
        logic [BYTE_W-1:0] bc;
        bit                reg_read;
        r = '0;
        // a byte joins the CRC only once two newer bytes are in the tail
        if (fm_count >= 2)
            fm_crc = crc16_step(fm_crc, fm_tail[0]);
        fm_tail[0] = fm_tail[1];
        fm_tail[1] = b;
        if (fm_count < HDR_N)
            fm_hdr[fm_count] = b;
        if (fm_count < COUNT_MAX)
            fm_count = fm_count + 1'b1;
        if (!l)
            return 1'b0;

        len      = fm_count;
        reg_read = c[1];
        rx_limit = reg_read ? BUF_REG : BUF_BIT;
        bc       = fm_hdr[2];
        if (len == 0 || len > rx_limit)
            r.status = ST_RXERR;
        else if (len < MIN_LEN)
            r.status = ST_SHORT;
        else if (fm_crc != {fm_tail[1], fm_tail[0]})
            r.status = ST_CRC;
        else if (fm_hdr[0] != fm_slave)
            r.status = ST_SLAVE;
        else if ((fm_hdr[1] & EXC_BIT) != 0)
        begin
            r.status   = ST_EXC;
            r.exc_code = fm_hdr[2];
        end
        else if (fm_hdr[1] != {6'b0, c} + 8'd1)
            r.status = ST_FUNC;
        else if (reg_read)
        begin
            if (len != REG_LEN || bc != REG_BYTES)
                r.status = ST_DATA;
            else
            begin
                r.status = ST_OK;
                r.value  = {fm_hdr[3], fm_hdr[4]};    // big endian register
            end
        end
        else
        begin
            if (bc == 0 || bc > 2 || {4'b0, len} != bc + MIN_LEN)
                r.status = ST_DATA;
            else
            begin
                r.status = ST_OK;                     // little endian bitfield
                r.value  = {(bc == 2) ? fm_hdr[4] : 8'h00, fm_hdr[3]};
            end
        end
        clear_frame_model();
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------
    function automatic void append_crc();
        logic [CRC_W-1:0] crc;
        crc = CRC_INIT;
        foreach (frame_buf[i])
            crc = crc16_step(crc, frame_buf[i]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endfunction

    // address, function, byte count, ndata data bytes, CRC
    function automatic void build_frame(input logic [BYTE_W-1:0] sa, fc, bc,
                                        input int ndata,
                                        input logic [BYTE_W-1:0] d0, d1);
        frame_buf.delete();
        frame_buf.push_back(sa);
        frame_buf.push_back(fc);
        frame_buf.push_back(bc);
        for (int i = 0; i < ndata; i++)
            frame_buf.push_back((i == 0) ? d0 : (i == 1) ? d1 : pick_data());
        append_crc();
    endfunction

    function automatic void build_raw(input int n, input bit with_crc);
        frame_buf.delete();
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
        if (with_crc)
            append_crc();
    endfunction

    function automatic void build_good(input logic [BYTE_W-1:0] sa, input logic [1:0] c);
        logic [BYTE_W-1:0] bc;
        if (c[1])
            build_frame(sa, {6'b0, c} + 8'd1, REG_BYTES, 2, pick_data(), pick_data());
        else
        begin
            bc = 8'($urandom_range(1, 2));
            build_frame(sa, {6'b0, c} + 8'd1, bc, bc, pick_data(), pick_data());
        end
    endfunction

    function automatic void build_exception(input logic [BYTE_W-1:0] sa,
                                            input logic [1:0] c);
        logic [BYTE_W-1:0] fc;
        fc = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : {6'b0, c} + 8'd1;
        build_frame(sa, fc | EXC_BIT, 8'($urandom_range(0, 255)), $urandom_range(0, 2),
                    pick_data(), pick_data());
    endfunction

    // one flaw per frame: CRC, address, function, byte count, length, short, long
    function automatic void build_broken(input logic [BYTE_W-1:0] sa, input logic [1:0] c);
        logic [BYTE_W-1:0] fc;
        int                idx;
        fc = {6'b0, c} + 8'd1;
        case ($urandom_range(0, 6))
            0:
            begin
                build_good(sa, c);
                idx = $urandom_range(0, frame_buf.size() - 1);
                frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            1: build_good(sa ^ 8'($urandom_range(1, 255)), c);
            2: build_frame(sa, fc ^ 8'($urandom_range(1, 127)), c[1] ? REG_BYTES : 8'd1,
                           c[1] ? 2 : 1, pick_data(), pick_data());
            3: build_frame(sa, fc, 8'($urandom_range(0, 255)),
                           c[1] ? 2 : $urandom_range(0, 3),
                           pick_data(), pick_data());
            4: build_frame(sa, fc, c[1] ? REG_BYTES : 8'($urandom_range(1, 2)),
                           c[1] ? 2 * $urandom_range(0, 1) + $urandom_range(0, 1) * 3 % 4
                                : $urandom_range(0, 3),
                           pick_data(), pick_data());
            5: build_raw($urandom_range(1, 4), 1'b0);
            default: build_raw($urandom_range(6, 18), 1'($urandom_range(0, 1)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Presents one item and holds it until accepted; valid stays high for
    // a following item unless that item opens with a gap.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic l, input logic [1:0] c);
        int          gap;
        mrc_result_t r;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        last     <= l;
        cmd      <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_frame_result(b, l, c, r))
            awaited_results.push_back(r);
        items_sent++;
    endtask

    // mixed_cmd: non-last bytes carry a random cmd, only the last one counts
    task automatic send_frame(input logic [1:0] c, input bit mixed_cmd);
        int n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
            send_item(frame_buf[i], i == n - 1,
                      (mixed_cmd && i != n - 1) ? 2'($urandom_range(0, 3)) : c);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // idle point for register writes: nothing awaited, pipeline flushed
    task automatic settle_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of slave_address, then a read back of the register
    task automatic write_slave_address(input logic [BYTE_W-1:0] sa);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SLAVE;
        pwdata  <= {{(DATA_W - BYTE_W){1'b0}}, sa};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        fm_slave = sa;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[BYTE_W-1:0] !== sa)
        begin
            $error("slave_address read back: expected %0h actual %0h", sa, prdata[BYTE_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: result check plus random receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mrc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with none awaited: status %0d value %0h exc_code %0h",
                       status, value, exc_code);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, status);
                    errors++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %0h actual %0h", want.value, value);
                    errors++;
                end
                if (exc_code !== want.exc_code)
                begin
                    $error("exc_code: expected %0h actual %0h",
                           want.exc_code, exc_code);
                    errors++;
                end
            end
        end

        // stall bursts alternate with open stretches
        if (!rx_stall_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (open_left > 0)
        begin
            out_stall <= 1'b0;
            open_left--;
        end
        else
        begin
            stall_left = pick_gap();
            open_left  = $urandom_range(0, 5);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("modbus_rtu_response_checker_unit_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset address 1, no idling: one-byte frame, full-scale register,
    // zero bitfield, exception with code FF, and a frame long enough to
    // saturate the byte counter.
    task automatic test_directed_frames();
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        build_raw(1, 1'b0);
        send_frame(CMD_INPUT, 1'b0);
        build_frame(SLAVE_RESET, {6'b0, CMD_INPUT} + 8'd1, REG_BYTES, 2, 8'hFF, 8'hFF);
        send_frame(CMD_INPUT, 1'b0);
        build_frame(SLAVE_RESET, {6'b0, CMD_COILS} + 8'd1, 8'd1, 1, 8'h00, 8'h00);
        send_frame(CMD_COILS, 1'b0);
        build_frame(SLAVE_RESET, ({6'b0, CMD_DISCRETE} + 8'd1) | EXC_BIT, 8'hFF, 0,
                    8'h00, 8'h00);
        send_frame(CMD_DISCRETE, 1'b0);
        build_raw(16, 1'b0);
        send_frame(CMD_HOLDING, 1'b0);
        settle_idle();
    endtask

    // address register at both ends of its range
    task automatic test_slave_extremes();
        logic [BYTE_W-1:0] sa;
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        for (int k = 0; k < 2; k++)
        begin
            sa = k ? 8'hFF : 8'h00;
            write_slave_address(sa);
            for (int c = 0; c < 4; c++)
            begin
                build_good(sa, c[1:0]);
                send_frame(c[1:0], 1'b0);
            end
            build_exception(sa, CMD_HOLDING);
            send_frame(CMD_HOLDING, 1'b0);
            build_good(~sa, CMD_COILS);
            send_frame(CMD_COILS, 1'b0);
            settle_idle();
        end
    endtask

    // sender holds off after each frame until its result is out
    task automatic test_paced_frames();
        logic [1:0] c;
        write_slave_address(8'($urandom_range(0, 255)));
        for (int k = 0; k < 8; k++)
        begin
            c = 2'($urandom_range(0, 3));
            if (k % 2)
                build_good(fm_slave, c);
            else
                build_broken(fm_slave, c);
            send_frame(c, 1'b0);
            wait_results();
        end
        settle_idle();
    endtask

    // Mostly well-formed frames with random content, some broken frames and
    // raw noise; address and idling change from phase to phase.
    task automatic test_random_traffic();
        int                target;
        int                next_phase;
        int                pick;
        logic [1:0]        c;
        logic [BYTE_W-1:0] sa;
        target     = items_sent + RANDOM_ITEMS;
        next_phase = items_sent;
        while (items_sent < target)
        begin
            if (items_sent >= next_phase)
            begin
                settle_idle();
                pick = $urandom_range(0, 3);
                write_slave_address((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                                    (pick == 2) ? SLAVE_RESET : 8'($urandom_range(0, 255)));
                tx_idle_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
                next_phase  = items_sent + $urandom_range(60, 120);
            end
            c    = 2'($urandom_range(0, 3));
            sa   = ($urandom_range(0, 99) < 85) ? fm_slave : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 48)
                build_good(sa, c);
            else if (pick < 58)
                build_exception(sa, c);
            else if (pick < 88)
                build_broken(sa, c);
            else
                build_raw($urandom_range(1, 12), 1'($urandom_range(0, 1)));
            send_frame(c, pick >= 88);
        end
        settle_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_slave_extremes();
        test_paced_frames();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("modbus_rtu_response_checker_unit_test: clean");
        else
            $display("modbus_rtu_response_checker_unit_test: errors");
        $finish;
    end

endmodule
